[sv/ps2md_pkg.sv]
// ps2md_pkg: types and constants shared by the ps/2 mouse packet decoder
// depends on nothing
`default_nettype none
package ps2md_pkg;

    localparam logic [1:0] EV_MOVE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    localparam logic [1:0] REG_FOUR_BYTE = 2'd0;
    localparam logic [1:0] REG_MAX_X     = 2'd1;
    localparam logic [1:0] REG_MAX_Y     = 2'd2;

    localparam logic [11:0] MAX_X_RESET = 12'd1023;
    localparam logic [11:0] MAX_Y_RESET = 12'd767;

    typedef struct packed {
        logic        four_byte_packets;
        logic [11:0] max_x;
        logic [11:0] max_y;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [4:0]  button_bits;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage
`default_nettype wire

[sv/ps2_mouse_packet_decoder.sv]
// ps2_mouse_packet_decoder: ps/2 mouse byte stream to pointer and button events
// an accepted byte is registered, then its results are written into the queue
// throughput: one byte per cycle; results leave one per cycle through the queue while
// m_ready is high; a held input word waits only while the queue lacks room for two words
// reset: position, buttons and byte count clear, max_x 1023, max_y 767, three-byte packets
// depends on ps2md_pkg, ps2md_core, ps2md_fifo
`default_nettype none
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [11:0]      m_pos_x,
    output logic [11:0]      m_pos_y,
    output logic [4:0]       m_button_bits,
    output logic             m_last,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_wr_data
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        room_for_two, process, pop;
    push_t       push;
    result_t     head;

    // input word goes through once the queue can take both possible results
    assign process = in_valid_reg && room_for_two;
    assign s_ready = !in_valid_reg || process;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.four_byte_packets <= 1'b0;
            cfg_reg.max_x             <= MAX_X_RESET;
            cfg_reg.max_y             <= MAX_Y_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FOUR_BYTE: cfg_reg.four_byte_packets <= cfg_wr_data[0];
                REG_MAX_X:     cfg_reg.max_x             <= cfg_wr_data;
                REG_MAX_Y:     cfg_reg.max_y             <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    ps2md_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (process),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .push      (push)
    );

    ps2md_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (pop),
        .room_for_two (room_for_two),
        .not_empty    (m_valid),
        .head         (head)
    );

    assign m_event_kind  = head.event_kind;
    assign m_pos_x       = head.pos_x;
    assign m_pos_y       = head.pos_y;
    assign m_button_bits = head.button_bits;
    assign m_last        = head.last;

endmodule
`default_nettype wire

[sv/ps2md_core.sv]
// ps2md_core: packet assembly, delta decode, position update and event build
// depends on ps2md_pkg
`default_nettype none
module ps2md_core
    import ps2md_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic [7:0] data_byte,
    input  wire cfg_t       cfg,
    output push_t           push
);

    logic [1:0]  byte_index_reg, byte_index_next;
    logic [7:0]  packet_bytes_reg [3];
    logic [11:0] position_x_reg, position_x_next;
    logic [11:0] position_y_reg, position_y_next;
    logic [4:0]  prev_buttons_reg;

    logic               complete;
    logic [7:0]         b0, b1, b2, b3;
    logic signed [9:0]  dx_raw, dy_raw;
    logic signed [11:0] dx_b, dy_b;
    logic signed [13:0] sum_x, sum_y;
    logic [4:0]         buttons;
    logic               wheel, moved, changed;
    result_t            move_ev, btn_ev;

    function automatic logic signed [11:0] boost(input logic signed [9:0] d);
        logic signed [11:0] w;
        w = {{2{d[9]}}, d};
        if (d > 10'sd5 || d < -10'sd5) begin
            return w + (w <<< 1);
        end
        return w;
    endfunction

    function automatic logic [11:0] clamp(input logic signed [13:0] p,
                                          input logic [11:0] mx);
        if (p < 14'sd0) begin
            return 12'd0;
        end
        if (p > $signed({2'b00, mx})) begin
            return mx;
        end
        return p[11:0];
    endfunction

    always_comb begin
        complete = cfg.four_byte_packets ? (byte_index_reg == 2'd3)
                                         : (byte_index_reg >= 2'd2);
        b0 = packet_bytes_reg[0];
        b1 = packet_bytes_reg[1];
        b2 = cfg.four_byte_packets ? packet_bytes_reg[2] : data_byte;
        b3 = cfg.four_byte_packets ? data_byte : 8'd0;

        dx_raw = {b0[4] ? 2'b11 : 2'b00, b1};
        dy_raw = $signed((b0[5] ? 10'd256 : 10'd0) - {2'b00, b2});
        dx_b   = boost(dx_raw);
        dy_b   = boost(dy_raw);
        sum_x  = $signed({2'b00, position_x_reg}) + {{2{dx_b[11]}}, dx_b};
        sum_y  = $signed({2'b00, position_y_reg}) + {{2{dy_b[11]}}, dy_b};
        position_x_next = clamp(sum_x, cfg.max_x);
        position_y_next = clamp(sum_y, cfg.max_y);

        wheel   = b3[3:0] != 4'd0;
        buttons = {b3[5], b3[4], b0[2:0]};
        moved   = (dx_b != 12'sd0) || (dy_b != 12'sd0) || wheel;
        changed = buttons != prev_buttons_reg;

        byte_index_next = complete ? 2'd0 : byte_index_reg + 2'd1;

        move_ev.event_kind  = EV_MOVE;
        move_ev.pos_x       = position_x_next;
        move_ev.pos_y       = position_y_next;
        move_ev.button_bits = buttons;
        move_ev.last        = !changed;

        btn_ev.event_kind  = (buttons != 5'd0) ? EV_PRESS : EV_RELEASE;
        btn_ev.pos_x       = position_x_next;
        btn_ev.pos_y       = position_y_next;
        btn_ev.button_bits = buttons;
        btn_ev.last        = 1'b1;

        push.count  = (en && complete) ? ({1'b0, moved} + {1'b0, changed}) : 2'd0;
        push.first  = moved ? move_ev : btn_ev;
        push.second = btn_ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg      <= 2'd0;
            packet_bytes_reg[0] <= 8'd0;
            packet_bytes_reg[1] <= 8'd0;
            packet_bytes_reg[2] <= 8'd0;
            position_x_reg      <= 12'd0;
            position_y_reg      <= 12'd0;
            prev_buttons_reg    <= 5'd0;
        end else if (en) begin
            byte_index_reg <= byte_index_next;
            if (complete) begin
                position_x_reg   <= position_x_next;
                position_y_reg   <= position_y_next;
                prev_buttons_reg <= buttons;
            end else begin
                packet_bytes_reg[byte_index_reg] <= data_byte;
            end
        end
    end

endmodule
`default_nettype wire

[sv/ps2md_fifo.sv]
// ps2md_fifo: result queue taking up to two words a cycle, giving one
// depends on ps2md_pkg
`default_nettype none
module ps2md_fifo
    import ps2md_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    input  wire logic  pop,
    output logic       room_for_two,
    output logic       not_empty,
    output result_t    head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next  = wr_ptr_reg + PW'(push.count);
        count_next   = count_reg + CW'(push.count) - CW'(pop);
        not_empty    = count_reg != CW'(0);
        room_for_two = count_reg <= CW'(DEPTH - 2);
        head         = entries_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for ps2_mouse_packet_decoder, predicting every event word from the
// byte stream and register writes, with random idling on both channels
// depends on ps2md_pkg and the ps2_mouse_packet_decoder rtl
module tb;
    import ps2md_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_event_kind;
    logic [11:0] m_pos_x;
    logic [11:0] m_pos_y;
    logic [4:0]  m_button_bits;
    logic        m_last;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = REG_FOUR_BYTE;
    logic [11:0] cfg_wr_data = 12'd0;

    // mirror of the decoder state
    bit          mode_four    = 1'b0;
    logic [11:0] lim_x        = MAX_X_RESET;
    logic [11:0] lim_y        = MAX_Y_RESET;
    int          byte_pos     = 0;
    logic [7:0]  pkt [3]      = '{8'h00, 8'h00, 8'h00};
    logic [11:0] ptr_x        = 12'd0;
    logic [11:0] ptr_y        = 12'd0;
    logic [4:0]  held_buttons = 5'd0;

    result_t pending_events[$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    bit      steady       = 1'b0;
    bit      hold_req     = 1'b0;
    int      rx_hold      = 0;
    int      rx_gap       = 0;

    ps2_mouse_packet_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_button_bits (m_button_bits),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic int boosted(int d);
        if (d > 5 || d < -5) return d * 3;
        return d;
    endfunction

    function automatic logic [11:0] clamped(int p, logic [11:0] lim);
        if (p > int'(lim)) return lim;
        if (p < 0) return 12'd0;
        return p[11:0];
    endfunction

    function automatic void decode_mouse_byte(logic [7:0] d);
        logic [7:0] b2;
        logic [7:0] b3;
        int         dx;
        int         dy;
        logic [4:0] btns;
        bit         moved;
        bit         changed;
        result_t    w;
        if ((mode_four && byte_pos < 3) || (!mode_four && byte_pos < 2)) begin
            pkt[byte_pos] = d;
            byte_pos++;
            return;
        end
        b2 = mode_four ? pkt[2] : d;
        b3 = mode_four ? d : 8'h00;
        byte_pos = 0;
        dx = pkt[0][4] ? int'(pkt[1]) - 256 : int'(pkt[1]);
        dy = pkt[0][5] ? 256 - int'(b2) : -int'(b2);
        moved = dx != 0 || dy != 0 || b3[3:0] != 4'h0;
        ptr_x = clamped(int'(ptr_x) + boosted(dx), lim_x);
        ptr_y = clamped(int'(ptr_y) + boosted(dy), lim_y);
        btns = {b3[5], b3[4], pkt[0][2:0]};
        changed = btns != held_buttons;
        held_buttons = btns;
        w.pos_x = ptr_x;
        w.pos_y = ptr_y;
        w.button_bits = btns;
        if (moved) begin
            w.event_kind = EV_MOVE;
            w.last = !changed;
            pending_events.push_back(w);
        end
        if (changed) begin
            w.event_kind = (btns != 5'd0) ? EV_PRESS : EV_RELEASE;
            w.last = 1'b1;
            pending_events.push_back(w);
        end
    endfunction

    function automatic logic [7:0] random_delta();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'h00;
        if (r < 40) return 8'($urandom_range(7, 1));
        if (r < 70) return 8'($urandom_range(255, 249));
        return 8'($urandom_range(255, 0));
    endfunction

    // shaped by where the byte falls in the packet, with some plain noise
    function automatic logic [7:0] random_mouse_byte();
        logic [7:0] b;
        b = 8'($urandom());
        if ($urandom_range(99) < 8) return b;
        if (byte_pos == 0) begin
            if ($urandom_range(99) < 70) b[2:0] = held_buttons[2:0];
            if ($urandom_range(99) < 85) b[3] = 1'b1;
            return b;
        end
        if (mode_four && byte_pos == 3) begin
            if ($urandom_range(99) < 40) b[3:0] = 4'h0;
            if ($urandom_range(99) < 60) b[5:4] = held_buttons[4:3];
            return b;
        end
        return random_delta();
    endfunction

    function automatic void report_mismatch(string msg);
        if (mismatches < 10) $display("mismatch: %s", msg);
        mismatches++;
    endfunction

    task automatic send_mouse_byte(logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        do @(posedge aclk); while (!s_ready);
        decode_mouse_byte(d);
    endtask

    task automatic send_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        send_mouse_byte(b0);
        send_mouse_byte(b1);
        send_mouse_byte(b2);
    endtask

    task automatic drain_events();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_decoder(bit four, logic [11:0] mx, logic [11:0] my);
        drain_events();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FOUR_BYTE;
        cfg_wr_data <= {11'd0, four};
        @(posedge aclk);
        cfg_index <= REG_MAX_X;
        cfg_wr_data <= mx;
        @(posedge aclk);
        cfg_index <= REG_MAX_Y;
        cfg_wr_data <= my;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_four = four;
        lim_x = mx;
        lim_y = my;
    endtask

    // reset settings: boost threshold, clamps at both ends, press and release
    task automatic test_three_byte_packets();
        send_packet(8'h29, 8'h05, 8'hFB);
        send_packet(8'h08, 8'h06, 8'h05);
        send_packet(8'h1F, 8'hFA, 8'h80);
        send_packet(8'h2F, 8'hFF, 8'h00);
        send_packet(8'h18, 8'h00, 8'h00);
        send_packet(8'h08, 8'h00, 8'h00);
    endtask

    // wheel only movement and the extra buttons
    task automatic test_four_byte_packets();
        program_decoder(1'b1, 12'hFFF, 12'hFFF);
        send_packet(8'h08, 8'h7F, 8'h00);
        send_mouse_byte(8'h00);
        send_packet(8'h08, 8'h00, 8'h00);
        send_mouse_byte(8'h30);
        send_packet(8'h08, 8'h00, 8'h00);
        send_mouse_byte(8'hFF);
        send_packet(8'h08, 8'h00, 8'h00);
        send_mouse_byte(8'h00);
    endtask

    // position already past the new limit is pulled in on the next packet
    task automatic test_lowered_max();
        program_decoder(1'b1, 12'd100, 12'hFFF);
        send_packet(8'h08, 8'h00, 8'h00);
        send_mouse_byte(8'h01);
        program_decoder(1'b0, 12'd0, 12'd0);
        send_packet(8'h08, 8'h7F, 8'h80);
    endtask

    task automatic test_mode_switch();
        program_decoder(1'b1, MAX_X_RESET, MAX_Y_RESET);
        send_mouse_byte(8'h08);
        send_mouse_byte(8'h05);
        program_decoder(1'b0, MAX_X_RESET, MAX_Y_RESET);
        send_mouse_byte(8'h03);
        send_mouse_byte(8'h09);
        send_mouse_byte(8'h01);
        program_decoder(1'b1, MAX_X_RESET, MAX_Y_RESET);
        send_mouse_byte(8'h00);
        send_mouse_byte(8'h20);
        send_packet(8'h08, 8'h02, 8'h02);
        program_decoder(1'b0, MAX_X_RESET, MAX_Y_RESET);
        send_mouse_byte(8'h04);
    endtask

    // results back up behind a stalled receiver until the input stalls too
    task automatic test_receiver_hold();
        program_decoder(1'b0, 12'hFFF, 12'hFFF);
        steady = 1'b1;
        hold_req <= 1'b1;
        repeat (48) send_mouse_byte(random_mouse_byte());
        steady = 1'b0;
        drain_events();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_decoder(1'b0, MAX_X_RESET, MAX_Y_RESET);
                1: program_decoder(1'b1, 12'hFFF, 12'hFFF);
                2: program_decoder(1'b0, 12'd0, 12'hFFF);
                3: program_decoder(1'b1, 12'hFFF, 12'd0);
                default: program_decoder(1'($urandom_range(1)), 12'($urandom_range(4095)),
                                         12'($urandom_range(4095)));
            endcase
            steady = (phase % 3 == 1);
            repeat ($urandom_range(125, 90)) send_mouse_byte(random_mouse_byte());
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req <= 1'b0;
            rx_hold <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap <= pick_gap();
        end
    end

    always @(posedge aclk) begin : check_words
        result_t seen;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_event_kind, m_pos_x, m_pos_y, m_button_bits, m_last};
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d x %0d y %0d buttons %b last %b",
                    seen.event_kind, seen.pos_x, seen.pos_y, seen.button_bits, seen.last));
            end else begin
                want = pending_events.pop_front();
                if (seen.event_kind !== want.event_kind || seen.pos_x !== want.pos_x ||
                    seen.pos_y !== want.pos_y || seen.button_bits !== want.button_bits ||
                    seen.last !== want.last) begin
                    report_mismatch($sformatf(
                        "kind/x/y/buttons/last expected %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                        want.event_kind, want.pos_x, want.pos_y, want.button_bits, want.last,
                        seen.event_kind, seen.pos_x, seen.pos_y, seen.button_bits, seen.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_three_byte_packets();
        test_four_byte_packets();
        test_lowered_max();
        test_mode_switch();
        test_receiver_hold();
        test_random_traffic();
        drain_events();
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
